// File: rtl/wsd_pkg.sv
package wsd_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int QDEPTH          = 2;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1023;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_LEN_ERR = 2'd2;

  localparam logic [2:0] CLS_TEXT  = 3'd0;
  localparam logic [2:0] CLS_CLOSE = 3'd1;
  localparam logic [2:0] CLS_PING  = 3'd2;
  localparam logic [2:0] CLS_PONG  = 3'd3;
  localparam logic [2:0] CLS_OTHER = 3'd4;

  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_PONG  = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  raw;
    logic [7:0]  key;
    logic        last;
    logic [2:0]  cls;
    logic [15:0] len;
  } item_t;

  function automatic logic [2:0] class_of(input logic [3:0] opc);
    logic [2:0] c;
    case (opc)
      OPC_TEXT:  c = CLS_TEXT;
      OPC_CLOSE: c = CLS_CLOSE;
      OPC_PING:  c = CLS_PING;
      OPC_PONG:  c = CLS_PONG;
      default:   c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/wsd_front.sv
module wsd_front #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                restart_i,
  input  logic [15:0]         max_payload_i,
  input  logic                q_full_i,
  output logic                push_o,
  output wsd_pkg::item_t      item_o
);

  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_EXT    = 3'd2;
  localparam logic [2:0] PH_KEY    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CLOSED = 3'd5;

  localparam logic [15:0] CAP16 = (LENGTH_BITS >= 16) ? 16'hFFFF :
                                  16'((64'd1 << LENGTH_BITS) - 64'd1);

  logic [2:0]             phase_q, phase_d;
  logic [3:0]             opc_q, opc_d;
  logic                   mask_q, mask_d;
  logic [15:0]            len_q, len_d;
  logic                   ovf_q, ovf_d;
  logic [3:0]             ext_left_q, ext_left_d;
  logic [31:0]            key_q, key_d;
  logic [2:0]             key_left_q, key_left_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;

  logic                   accept;
  logic [15:0]            limit;
  logic                   fh;
  logic [15:0]            fh_len;
  logic                   fh_ovf;
  logic [LENGTH_BITS-1:0] cnt_n;
  logic                   data_last;
  logic [7:0]             kb;
  logic                   is_close;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign limit      = (max_payload_i < CAP16) ? max_payload_i : CAP16;
  assign is_close   = (wsd_pkg::class_of(opc_q) == wsd_pkg::CLS_CLOSE);
  assign cnt_n      = cnt_q + LENGTH_BITS'(1);
  assign data_last  = (32'(cnt_n) == 32'(len_q));

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    kb = key_q[31:24];
      2'd1:    kb = key_q[23:16];
      2'd2:    kb = key_q[15:8];
      default: kb = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    opc_d      = opc_q;
    mask_d     = mask_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    ext_left_d = ext_left_q;
    key_d      = key_q;
    key_left_d = key_left_q;
    cnt_d      = cnt_q;
    push_o     = 1'b0;
    item_o     = '0;
    item_o.cls = wsd_pkg::class_of(opc_q);
    fh         = 1'b0;
    fh_len     = len_q;
    fh_ovf     = ovf_q;
    if (accept) begin
      if (restart_i) begin
        phase_d    = PH_HDR0;
        opc_d      = '0;
        mask_d     = 1'b0;
        len_d      = '0;
        ovf_d      = 1'b0;
        ext_left_d = '0;
        key_d      = '0;
        key_left_d = '0;
        cnt_d      = '0;
      end else begin
        case (phase_q)
          PH_HDR0: begin
            opc_d   = rx_byte_i[3:0];
            mask_d  = 1'b0;
            key_d   = '0;
            len_d   = '0;
            ovf_d   = 1'b0;
            cnt_d   = '0;
            phase_d = PH_HDR1;
          end
          PH_HDR1: begin
            mask_d = rx_byte_i[7];
            len_d  = '0;
            ovf_d  = 1'b0;
            if (rx_byte_i[6:0] == wsd_pkg::LEN7_EXT16) begin
              ext_left_d = wsd_pkg::EXT16_BYTES;
              phase_d    = PH_EXT;
            end else if (rx_byte_i[6:0] == wsd_pkg::LEN7_EXT64) begin
              ext_left_d = wsd_pkg::EXT64_BYTES;
              phase_d    = PH_EXT;
            end else begin
              len_d = {9'd0, rx_byte_i[6:0]};
              if (rx_byte_i[7]) begin
                key_left_d = wsd_pkg::KEY_BYTES;
                phase_d    = PH_KEY;
              end else begin
                fh     = 1'b1;
                fh_len = len_d;
                fh_ovf = 1'b0;
              end
            end
          end
          PH_EXT: begin
            len_d      = {len_q[7:0], rx_byte_i};
            ovf_d      = ovf_q | (len_q[15:8] != 8'd0);
            ext_left_d = (ext_left_q != 4'd0) ? ext_left_q - 4'd1 : 4'd0;
            if (ext_left_d == 4'd0) begin
              if (mask_q) begin
                key_left_d = wsd_pkg::KEY_BYTES;
                phase_d    = PH_KEY;
              end else begin
                fh     = 1'b1;
                fh_len = len_d;
                fh_ovf = ovf_d;
              end
            end
          end
          PH_KEY: begin
            key_d      = {key_q[23:0], rx_byte_i};
            key_left_d = (key_left_q != 3'd0) ? key_left_q - 3'd1 : 3'd0;
            if (key_left_d == 3'd0) begin
              fh = 1'b1;
            end
          end
          PH_DATA: begin
            cnt_d       = cnt_n;
            push_o      = 1'b1;
            item_o.kind = wsd_pkg::KIND_PAYLOAD;
            item_o.raw  = rx_byte_i;
            item_o.key  = kb;
            item_o.last = data_last;
            item_o.len  = len_q;
            if (data_last) begin
              phase_d = is_close ? PH_CLOSED : PH_HDR0;
            end
          end
          default: begin
            phase_d = PH_CLOSED;
          end
        endcase
        if (fh) begin
          if (fh_ovf || (fh_len > limit)) begin
            push_o      = 1'b1;
            item_o.kind = wsd_pkg::KIND_LEN_ERR;
            item_o.last = 1'b1;
            item_o.len  = fh_ovf ? 16'hFFFF : fh_len;
            phase_d     = PH_CLOSED;
          end else if (fh_len == 16'd0) begin
            push_o      = 1'b1;
            item_o.kind = wsd_pkg::KIND_EMPTY;
            item_o.last = 1'b1;
            item_o.len  = 16'd0;
            phase_d     = is_close ? PH_CLOSED : PH_HDR0;
          end else begin
            cnt_d   = '0;
            phase_d = PH_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      opc_q      <= '0;
      mask_q     <= 1'b0;
      len_q      <= '0;
      ovf_q      <= 1'b0;
      ext_left_q <= '0;
      key_q      <= '0;
      key_left_q <= '0;
      cnt_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      opc_q      <= opc_d;
      mask_q     <= mask_d;
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      ext_left_q <= ext_left_d;
      key_q      <= key_d;
      key_left_q <= key_left_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

// File: rtl/wsd_queue.sv
module wsd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wsd_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output wsd_pkg::item_t item_o
);

  localparam int DEPTH = wsd_pkg::QDEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  wsd_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("queue count did not advance");
`endif

endmodule

// File: rtl/wsd_back.sv
module wsd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  wsd_pkg::item_t q_item_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     kind_o,
  output logic [7:0]     payload_byte_o,
  output logic           last_of_frame_o,
  output logic [2:0]     frame_class_o,
  output logic [15:0]    frame_length_o
);

  logic        valid_q, valid_d;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [2:0]  cls_q;
  logic [15:0] len_q;

  assign pop_o   = q_valid_i && (!valid_q || !out_stall_i);
  assign valid_d = pop_o ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= q_item_i.kind;
      byte_q <= q_item_i.raw ^ q_item_i.key;
      last_q <= q_item_i.last;
      cls_q  <= q_item_i.cls;
      len_q  <= q_item_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = kind_q;
  assign payload_byte_o  = byte_q;
  assign last_of_frame_o = last_q;
  assign frame_class_o   = cls_q;
  assign frame_length_o  = len_q;

endmodule

// File: rtl/websocket_frame_deframer_core.sv
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o  rx_byte_i, restart_i
// out       output     out_valid_o/out_stall_i kind_o, payload_byte_o, last_of_frame_o,
//                                              frame_class_o, frame_length_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (max_payload)
//
// One input item per cycle while in_stall_o is low; each result passes through a queue entry
// (written at the accepting edge), then the output register.
// Reset clears the parser, the queue and the output valid; max_payload resets to 1023.
// in_stall_o rises only while the queue is full, which takes two queued results behind
// a stalled output register; cfg_ready_o is always high.
module websocket_frame_deframer_core #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_frame_o,
  output logic [2:0]  frame_class_o,
  output logic [15:0] frame_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]    max_payload_q;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  wsd_pkg::item_t push_item;
  wsd_pkg::item_t head_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= wsd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_payload_q <= cfg_data_i;
    end
  end

  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .restart_i     (restart_i),
    .max_payload_i (max_payload_q),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .item_o        (push_item)
  );

  wsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  wsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (head_item),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .last_of_frame_o (last_of_frame_o),
    .frame_class_o   (frame_class_o),
    .frame_length_o  (frame_length_o)
  );

endmodule

// File: dv/tb_websocket_frame_deframer_core.sv
module tb_websocket_frame_deframer_core;
  import wsd_pkg::*;

  localparam int ITEM_TARGET   = 900;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 100;

  localparam logic [3:0] OPC_CONT   = 4'h0;
  localparam logic [3:0] OPC_BINARY = 4'h2;

  typedef enum logic [2:0] {
    PH_HEADER0,
    PH_HEADER1,
    PH_EXT_LEN,
    PH_MASK_KEY,
    PH_PAYLOAD,
    PH_CLOSED
  } parse_phase_e;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  cls;
    logic [15:0] len;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic        last_of_frame_o;
  logic [2:0]  frame_class_o;
  logic [15:0] frame_length_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = 16'h0000;

  parse_phase_e phase = PH_HEADER0;
  logic [3:0]   hdr_opcode = 4'h0;
  logic         hdr_masked = 1'b0;
  logic [63:0]  frame_len = 64'd0;
  logic [3:0]   ext_left = 4'd0;
  logic [31:0]  mask_word = 32'd0;
  logic [2:0]   key_left = 3'd0;
  logic [15:0]  data_count = 16'd0;
  logic [15:0]  max_len_cfg = MAX_PAYLOAD_RST;

  frame_result_t pending_results[$];

  int errors = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int kind_count [3] = '{0, 0, 0};

  logic        send_idle = 1'b1;
  logic        recv_idle = 1'b1;
  int          hold_cycles = 0;
  int          stall_left = 0;
  int          useful_items = 0;
  logic        stim_closed = 1'b0;
  logic [15:0] cur_max = MAX_PAYLOAD_RST;

  websocket_frame_deframer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .last_of_frame_o(last_of_frame_o),
    .frame_class_o  (frame_class_o),
    .frame_length_o (frame_length_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [2:0] class_for(input logic [3:0] opc);
    case (opc)
      OPC_TEXT:  return CLS_TEXT;
      OPC_CLOSE: return CLS_CLOSE;
      OPC_PING:  return CLS_PING;
      OPC_PONG:  return CLS_PONG;
      default:   return CLS_OTHER;
    endcase
  endfunction

  task automatic expect_result(input logic [1:0] kind, input logic [7:0] data,
                               input logic last, input logic [15:0] len);
    frame_result_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    r.cls  = class_for(hdr_opcode);
    r.len  = len;
    pending_results.push_back(r);
  endtask

  task automatic end_of_header();
    if (frame_len > {48'd0, max_len_cfg}) begin
      expect_result(KIND_LEN_ERR, 8'h00, 1'b1,
                    (frame_len > 64'hFFFF) ? 16'hFFFF : frame_len[15:0]);
      phase = PH_CLOSED;
    end else if (frame_len == 64'd0) begin
      expect_result(KIND_EMPTY, 8'h00, 1'b1, 16'd0);
      phase = (class_for(hdr_opcode) == CLS_CLOSE) ? PH_CLOSED : PH_HEADER0;
    end else begin
      data_count = 16'd0;
      phase = PH_PAYLOAD;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic rs);
    logic [7:0] kb;
    logic       last;
    if (rs) begin
      phase      = PH_HEADER0;
      hdr_opcode = 4'h0;
      hdr_masked = 1'b0;
      frame_len  = 64'd0;
      ext_left   = 4'd0;
      mask_word  = 32'd0;
      key_left   = 3'd0;
      data_count = 16'd0;
      return;
    end
    case (phase)
      PH_HEADER0: begin
        hdr_opcode = b[3:0];
        hdr_masked = 1'b0;
        mask_word  = 32'd0;
        frame_len  = 64'd0;
        data_count = 16'd0;
        phase      = PH_HEADER1;
      end
      PH_HEADER1: begin
        hdr_masked = b[7];
        frame_len  = 64'd0;
        if (b[6:0] == LEN7_EXT16) begin
          ext_left = EXT16_BYTES;
          phase    = PH_EXT_LEN;
        end else if (b[6:0] == LEN7_EXT64) begin
          ext_left = EXT64_BYTES;
          phase    = PH_EXT_LEN;
        end else begin
          frame_len = {57'd0, b[6:0]};
          if (hdr_masked) begin
            key_left = KEY_BYTES;
            phase    = PH_MASK_KEY;
          end else begin
            end_of_header();
          end
        end
      end
      PH_EXT_LEN: begin
        frame_len = {frame_len[55:0], b};
        if (ext_left != 4'd0) ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) begin
          if (hdr_masked) begin
            key_left = KEY_BYTES;
            phase    = PH_MASK_KEY;
          end else begin
            end_of_header();
          end
        end
      end
      PH_MASK_KEY: begin
        mask_word = {mask_word[23:0], b};
        if (key_left != 3'd0) key_left = key_left - 3'd1;
        if (key_left == 3'd0) end_of_header();
      end
      PH_PAYLOAD: begin
        kb = mask_word[8 * (3 - data_count[1:0]) +: 8];
        data_count = data_count + 16'd1;
        last = ({48'd0, data_count} == frame_len);
        expect_result(KIND_PAYLOAD, b ^ kb, last, frame_len[15:0]);
        if (last) phase = (class_for(hdr_opcode) == CLS_CLOSE) ? PH_CLOSED : PH_HEADER0;
      end
      default: phase = PH_CLOSED;
    endcase
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    frame_result_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_cfg = cfg_data_i;
        cfg_writes++;
      end
      if (in_valid_i && !in_stall_o) begin
        bytes_taken++;
        deframe_byte(rx_byte_i, restart_i);
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got kind %0d byte %0d",
                     $time, kind_o, payload_byte_o);
        end else begin
          e = pending_results.pop_front();
          kind_count[e.kind]++;
          check_field("kind", {14'd0, e.kind}, {14'd0, kind_o});
          check_field("payload_byte", {8'd0, e.data}, {8'd0, payload_byte_o});
          check_field("last_of_frame", {15'd0, e.last}, {15'd0, last_of_frame_o});
          check_field("frame_class", {13'd0, e.cls}, {13'd0, frame_class_o});
          check_field("frame_length", e.len, frame_length_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin : out_side
    int n;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      n = stall_left;
      if (out_valid_o && !out_stall_i) n = recv_idle ? $urandom_range(0, 12) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        stall_left = n - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = 0;
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic rs);
    int gap;
    gap = send_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    restart_i  <= rs;
    do @(posedge clk_i); while (in_stall_o);
    if (!stim_closed || rs) useful_items++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_max_payload(input logic [15:0] value);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_max = value;
  endtask

  // form: 0 = 7-bit length, 1 = 16-bit extended, 2 = 64-bit extended
  // cut: payload bytes sent before a restart, or -1 for the whole frame
  task automatic send_frame(input logic [3:0] opc, input logic masked,
                            input logic [63:0] len, input int form, input int cut);
    logic [3:0]  flags;
    logic [31:0] key;
    logic [6:0]  len7;
    logic        over;
    int          n;
    flags = 4'($urandom_range(0, 15));
    key   = $urandom;
    case (form)
      0:       len7 = len[6:0];
      1:       len7 = LEN7_EXT16;
      default: len7 = LEN7_EXT64;
    endcase
    send_byte({flags, opc}, 1'b0);
    send_byte({masked, len7}, 1'b0);
    if (form == 1) begin
      for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8], 1'b0);
    end else if (form == 2) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8], 1'b0);
    end
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8], 1'b0);
    end
    over = len > {48'd0, cur_max};
    n = over ? 0 : int'(len);
    if (cut >= 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    if (over || (opc == OPC_CLOSE && 64'(n) == len)) begin
      stim_closed = 1'b1;
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      stim_closed = 1'b0;
    end else if (64'(n) < len) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_directed_headers();
    send_byte(8'h81, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h89, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h8A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_close_frames();
    send_frame(OPC_CLOSE, 1'b1, 64'd3, 0, -1);
    send_frame(OPC_CLOSE, 1'b0, 64'd0, 0, -1);
    send_frame(OPC_TEXT, 1'b0, 64'd4, 0, -1);
    send_frame(OPC_CLOSE, 1'b1, 64'd0, 1, -1);
  endtask

  task automatic test_extended_lengths();
    send_frame(OPC_TEXT, 1'b0, 64'd125, 0, -1);
    send_frame(OPC_PING, 1'b1, 64'd130, 1, -1);
    send_frame(OPC_PONG, 1'b0, 64'd0, 1, -1);
    send_frame(OPC_TEXT, 1'b0, 64'd5, 2, -1);
    send_frame(OPC_CONT, 1'b1, 64'd0, 2, -1);
    send_frame(OPC_PONG, 1'b1, 64'h8000_0000_0000_0001, 2, -1);
    send_frame(OPC_TEXT, 1'b0, 64'h1_0000, 2, -1);
    send_frame(OPC_BINARY, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 2, -1);
  endtask

  task automatic test_backpressure();
    hold_cycles = 150;
    send_frame(OPC_TEXT, 1'b1, 64'd30, 1, -1);
    wait_drain();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_frame(OPC_PING, 1'b0, 64'd40, 1, -1);
    send_frame(OPC_PONG, 1'b1, 64'd0, 0, -1);
    hold_cycles = 60;
    repeat (3) send_frame(OPC_BINARY, 1'b1, 64'd12, 0, -1);
    wait_drain();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_length_limits();
    logic [15:0] limits [5];
    limits = '{16'd0, 16'd1, 16'd37, 16'd65534, 16'hFFFF};
    foreach (limits[i]) begin
      set_max_payload(limits[i]);
      if (limits[i] <= 16'd64) send_frame(OPC_TEXT, 1'b1, {48'd0, limits[i]}, 1, -1);
      send_frame(OPC_PING, 1'b0, 64'd0, 0, -1);
      if (limits[i] != 16'hFFFF) begin
        send_frame(OPC_PONG, 1'b1, {48'd0, limits[i]} + 64'd1, 1, -1);
      end else begin
        send_frame(OPC_PONG, 1'b1, 64'h1_0000, 2, -1);
      end
    end
    set_max_payload(MAX_PAYLOAD_RST);
  endtask

  task automatic test_random_traffic();
    int          frames;
    int          r;
    int          form;
    int          cut;
    logic [3:0]  opc;
    logic        masked;
    logic [63:0] len;
    frames = 0;
    while (useful_items < ITEM_TARGET) begin
      if (frames % 16 == 0) begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      if (frames % 8 == 7) begin
        case ($urandom_range(0, 4))
          0:       set_max_payload(16'($urandom_range(0, 20)));
          1:       set_max_payload(16'($urandom_range(21, 400)));
          2:       set_max_payload(MAX_PAYLOAD_RST);
          3:       set_max_payload(16'hFFFF);
          default: set_max_payload(16'($urandom_range(0, 65535)));
        endcase
      end
      frames++;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (r < 9) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30)      opc = OPC_TEXT;
        else if (r < 45) opc = OPC_PING;
        else if (r < 60) opc = OPC_PONG;
        else if (r < 65) opc = OPC_CLOSE;
        else             opc = 4'($urandom_range(0, 15));
        masked = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 60) begin
          form = 0;
          len  = 64'($urandom_range(0, 10));
        end else if (r < 65) begin
          form = 0;
          len  = 64'($urandom_range(11, 125));
        end else if (r < 80) begin
          form = 1;
          len  = 64'($urandom_range(0, 60));
        end else if (r < 83) begin
          form = 1;
          len  = 64'($urandom_range(126, 400));
        end else if (r < 92) begin
          form = 2;
          len  = 64'($urandom_range(0, 40));
        end else if (cur_max != 16'hFFFF && r < 96) begin
          form = 1;
          len  = 64'($urandom_range(int'(cur_max) + 1, 65535));
        end else begin
          form = 2;
          len  = {$urandom, $urandom};
          if (len[63:16] == '0) len[16] = 1'b1;
        end
        cut = -1;
        if ($urandom_range(0, 9) == 0 && len > 64'd0 && len < 64'd400)
          cut = $urandom_range(0, int'(len) - 1);
        send_frame(opc, masked, len, form, cut);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_headers();
    test_close_frames();
    test_extended_lengths();
    test_backpressure();
    test_length_limits();
    test_random_traffic();
    wait_drain();
    $display("Covered %0d input items and %0d results over %0d max_payload writes,",
             bytes_taken, results_seen, cfg_writes);
    $display("with %0d payload bytes, %0d empty frames and %0d length errors.",
             kind_count[0], kind_count[1], kind_count[2]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/wsd_pkg.sv
rtl/wsd_front.sv
rtl/wsd_queue.sv
rtl/wsd_back.sv
rtl/websocket_frame_deframer_core.sv
dv/tb_websocket_frame_deframer_core.sv
